[rtl/ep2cal_pkg.sv]
// Shared types, microcode encodings and constant tables for the epoch-to-calendar converter.
`default_nettype none

package ep2cal_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Micro-operations of the datapath
    typedef enum logic [2:0] {
        OP_IDLE,    // wait for an input beat
        OP_MUL,     // product <= operand * reciprocal
        OP_DIV,     // quotient <= product >> shift
        OP_REM,     // remainder into its field, quotient forward
        OP_YEAR,    // one year of the walk, exit when days fit
        OP_MONTH,   // one month of the walk, exit when days fit
        OP_EMIT     // load the output register, back to idle
    } op_t;

    // Divisor selector
    typedef enum logic [1:0] {
        DV_SEC,
        DV_MIN,
        DV_HOUR,
        DV_WDAY
    } dsel_t;

    typedef struct packed {
        op_t   op;
        dsel_t sel;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } dstat_t;

    typedef struct packed {
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } result_t;

    localparam logic [11:0] YEAR_BASE      = 12'd1970;
    localparam logic [8:0]  YEAR_BASE_M400 = 9'd370;
    localparam logic [8:0]  YEAR_M400_LAST = 9'd399;
    localparam logic [8:0]  DAYS_LEAP      = 9'd366;
    localparam logic [8:0]  DAYS_COMMON    = 9'd365;
    localparam logic [15:0] WDAY_BASE      = 16'd4;   // 1970-01-01 was a Thursday

    // Reciprocal constants: floor(x * M >> S) == floor(x / D) over the operand range
    function automatic logic [31:0] recip(input dsel_t sel);
        case (sel)
            DV_SEC:  recip = 32'h8888_8889;
            DV_MIN:  recip = 32'h8888_8889;
            DV_HOUR: recip = 32'hAAAA_AAAB;
            DV_WDAY: recip = 32'h2492_4925;
            default: recip = 32'h8888_8889;
        endcase
    endfunction

    function automatic logic [5:0] divisor(input dsel_t sel);
        case (sel)
            DV_SEC:  divisor = 6'd60;
            DV_MIN:  divisor = 6'd60;
            DV_HOUR: divisor = 6'd24;
            DV_WDAY: divisor = 6'd7;
            default: divisor = 6'd60;
        endcase
    endfunction

    // Gregorian rule from year mod 400
    function automatic logic is_leap(input logic [8:0] y400);
        is_leap = (y400[1:0] == 2'd0) &&
                  (y400 != 9'd100) && (y400 != 9'd200) && (y400 != 9'd300);
    endfunction

    // Month length, month counted from 0
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m)
            4'd0:    month_len = 5'd31;
            4'd1:    month_len = leap ? 5'd29 : 5'd28;
            4'd2:    month_len = 5'd31;
            4'd3:    month_len = 5'd30;
            4'd4:    month_len = 5'd31;
            4'd5:    month_len = 5'd30;
            4'd6:    month_len = 5'd31;
            4'd7:    month_len = 5'd31;
            4'd8:    month_len = 5'd30;
            4'd9:    month_len = 5'd31;
            4'd10:   month_len = 5'd30;
            4'd11:   month_len = 5'd31;
            default: month_len = 5'd31;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/epoch_seconds_to_calendar_core.sv]
// Top level: microcoded epoch-seconds to calendar date and time converter.
`default_nettype none

// Channel   Dir  Beat content                                   Handshake
// s_axis    in   epoch_seconds[31:0]                            tvalid/tready
// m_axis    out  second, minute, hour, weekday, year, month,    tvalid/tready
//                day_of_month packed in tdata[40:0]
//
// A beat runs through the program in order: accept, 12 steps
// of reciprocal multiply division (second, minute, hour, weekday), a walk over the years
// from 1970 and one over the months, each left at a step where the days fit, then emit.
// The output register holds a finished result while the next beat is accepted;
// the emit step waits only while that register is full and not draining.
// rst_n clears the step counter and output valid; no memories to clear.

module epoch_seconds_to_calendar_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                        // [19:17] weekday, [31:20] year,
                                        // [35:32] month, [40:36] day_of_month
);

    ep2cal_pkg::step_t   step_reg, step_next;
    logic                oval_reg, oval_next;
    logic [47:0]         odata_reg, odata_next;

    ep2cal_pkg::uword_t  uword;
    ep2cal_pkg::dstat_t  stat;
    ep2cal_pkg::result_t res;

    logic accept;
    logic emit;

    ep2cal_urom u_urom (
        .step (step_reg),
        .word (uword)
    );

    ep2cal_dpath u_dpath (
        .clk           (clk),
        .start         (accept),
        .epoch_seconds (s_axis_tdata),
        .ctl           (uword),
        .stat          (stat),
        .res           (res)
    );

    assign s_axis_tready = (uword.op == ep2cal_pkg::OP_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // emit only when the output register is free or drains this cycle
    assign emit          = (uword.op == ep2cal_pkg::OP_EMIT) && (!oval_reg || m_axis_tready);

    always_comb
    begin
        step_next = step_reg;
        case (uword.op)
            ep2cal_pkg::OP_IDLE:  if (accept)         step_next = step_reg + 4'd1;
            ep2cal_pkg::OP_YEAR:  if (stat.year_fit)  step_next = uword.target;
            ep2cal_pkg::OP_MONTH: if (stat.month_fit) step_next = uword.target;
            ep2cal_pkg::OP_EMIT:  if (emit)           step_next = uword.target;
            default:                                  step_next = step_reg + 4'd1;
        endcase
    end

    always_comb
    begin
        oval_next  = oval_reg;
        odata_next = odata_reg;
        if (oval_reg && m_axis_tready)
        begin
            oval_next = 1'b0;
        end
        if (emit)
        begin
            oval_next  = 1'b1;
            odata_next = {7'd0, res.day_of_month, res.month, res.year, res.weekday,
                          res.hour, res.minute, res.second};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = odata_reg;

endmodule

`default_nettype wire

[rtl/ep2cal_urom.sv]
// Control store: one micro-instruction per step of the conversion program.
`default_nettype none

module ep2cal_urom (
    input  wire ep2cal_pkg::step_t  step,
    output ep2cal_pkg::uword_t      word
);

    always_comb
    begin
        word.target = '0;
        case (step)
            4'd0:    begin word.op = ep2cal_pkg::OP_IDLE;  word.sel = ep2cal_pkg::DV_SEC;  end
            4'd1:    begin word.op = ep2cal_pkg::OP_MUL;   word.sel = ep2cal_pkg::DV_SEC;  end
            4'd2:    begin word.op = ep2cal_pkg::OP_DIV;   word.sel = ep2cal_pkg::DV_SEC;  end
            4'd3:    begin word.op = ep2cal_pkg::OP_REM;   word.sel = ep2cal_pkg::DV_SEC;  end
            4'd4:    begin word.op = ep2cal_pkg::OP_MUL;   word.sel = ep2cal_pkg::DV_MIN;  end
            4'd5:    begin word.op = ep2cal_pkg::OP_DIV;   word.sel = ep2cal_pkg::DV_MIN;  end
            4'd6:    begin word.op = ep2cal_pkg::OP_REM;   word.sel = ep2cal_pkg::DV_MIN;  end
            4'd7:    begin word.op = ep2cal_pkg::OP_MUL;   word.sel = ep2cal_pkg::DV_HOUR; end
            4'd8:    begin word.op = ep2cal_pkg::OP_DIV;   word.sel = ep2cal_pkg::DV_HOUR; end
            4'd9:    begin word.op = ep2cal_pkg::OP_REM;   word.sel = ep2cal_pkg::DV_HOUR; end
            4'd10:   begin word.op = ep2cal_pkg::OP_MUL;   word.sel = ep2cal_pkg::DV_WDAY; end
            4'd11:   begin word.op = ep2cal_pkg::OP_DIV;   word.sel = ep2cal_pkg::DV_WDAY; end
            4'd12:   begin word.op = ep2cal_pkg::OP_REM;   word.sel = ep2cal_pkg::DV_WDAY; end
            4'd13:
            begin
                word.op     = ep2cal_pkg::OP_YEAR;
                word.sel    = ep2cal_pkg::DV_SEC;
                word.target = 4'd14;
            end
            4'd14:
            begin
                word.op     = ep2cal_pkg::OP_MONTH;
                word.sel    = ep2cal_pkg::DV_SEC;
                word.target = 4'd15;
            end
            4'd15:
            begin
                word.op     = ep2cal_pkg::OP_EMIT;
                word.sel    = ep2cal_pkg::DV_SEC;
                word.target = 4'd0;
            end
            default: begin word.op = ep2cal_pkg::OP_IDLE;  word.sel = ep2cal_pkg::DV_SEC;  end
        endcase
    end

endmodule

`default_nettype wire

[rtl/ep2cal_dpath.sv]
// Datapath: reciprocal multiply divider, year and month walkers, field registers.
`default_nettype none

module ep2cal_dpath (
    input  wire                     clk,
    input  wire                     start,
    input  wire [31:0]              epoch_seconds,
    input  wire ep2cal_pkg::uword_t ctl,
    output ep2cal_pkg::dstat_t      stat,
    output ep2cal_pkg::result_t     res
);

    logic [31:0] acc_reg,   acc_next;
    logic [63:0] prod_reg,  prod_next;
    logic [31:0] quo_reg,   quo_next;
    logic [15:0] days_reg,  days_next;
    logic [11:0] year_reg,  year_next;
    logic [8:0]  y400_reg,  y400_next;
    logic [3:0]  month_reg, month_next;
    logic [5:0]  sec_reg,   sec_next;
    logic [5:0]  min_reg,   min_next;
    logic [4:0]  hour_reg,  hour_next;
    logic [2:0]  wday_reg,  wday_next;

    logic [31:0] opnd;
    logic [31:0] rem;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    always_comb
    begin
        opnd = (ctl.sel == ep2cal_pkg::DV_WDAY) ?
               {16'd0, days_reg + ep2cal_pkg::WDAY_BASE} : acc_reg;
        rem  = opnd - 32'(quo_reg * {26'd0, ep2cal_pkg::divisor(ctl.sel)});
        leap = ep2cal_pkg::is_leap(y400_reg);
        ylen = leap ? ep2cal_pkg::DAYS_LEAP : ep2cal_pkg::DAYS_COMMON;
        mlen = ep2cal_pkg::month_len(month_reg, leap);
        stat.year_fit  = days_reg < {7'd0, ylen};
        stat.month_fit = days_reg < {11'd0, mlen};
    end

    always_comb
    begin
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        y400_next  = y400_reg;
        month_next = month_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        wday_next  = wday_reg;
        case (ctl.op)
            ep2cal_pkg::OP_IDLE:
            begin
                if (start)
                begin
                    acc_next   = epoch_seconds;
                    year_next  = ep2cal_pkg::YEAR_BASE;
                    y400_next  = ep2cal_pkg::YEAR_BASE_M400;
                    month_next = '0;
                end
            end
            ep2cal_pkg::OP_MUL:
            begin
                prod_next = {32'd0, opnd} * {32'd0, ep2cal_pkg::recip(ctl.sel)};
            end
            ep2cal_pkg::OP_DIV:
            begin
                case (ctl.sel)
                    ep2cal_pkg::DV_HOUR: quo_next = {4'd0, prod_reg[63:36]};
                    ep2cal_pkg::DV_WDAY: quo_next = prod_reg[63:32];
                    default:             quo_next = {5'd0, prod_reg[63:37]};
                endcase
            end
            ep2cal_pkg::OP_REM:
            begin
                case (ctl.sel)
                    ep2cal_pkg::DV_SEC:
                    begin
                        sec_next = rem[5:0];
                        acc_next = quo_reg;
                    end
                    ep2cal_pkg::DV_MIN:
                    begin
                        min_next = rem[5:0];
                        acc_next = quo_reg;
                    end
                    ep2cal_pkg::DV_HOUR:
                    begin
                        hour_next = rem[4:0];
                        days_next = quo_reg[15:0];
                    end
                    default:
                    begin
                        wday_next = rem[2:0];
                    end
                endcase
            end
            ep2cal_pkg::OP_YEAR:
            begin
                if (!stat.year_fit)
                begin
                    days_next = days_reg - {7'd0, ylen};
                    year_next = year_reg + 12'd1;
                    y400_next = (y400_reg == ep2cal_pkg::YEAR_M400_LAST) ? 9'd0
                                                                         : y400_reg + 9'd1;
                end
            end
            ep2cal_pkg::OP_MONTH:
            begin
                if (!stat.month_fit)
                begin
                    days_next  = days_reg - {11'd0, mlen};
                    month_next = month_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        quo_reg   <= quo_next;
        days_reg  <= days_next;
        year_reg  <= year_next;
        y400_reg  <= y400_next;
        month_reg <= month_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hour_reg  <= hour_next;
        wday_reg  <= wday_next;
    end

    always_comb
    begin
        res.second       = sec_reg;
        res.minute       = min_reg;
        res.hour         = hour_reg;
        res.weekday      = wday_reg;
        res.year         = year_reg;
        res.month        = month_reg + 4'd1;
        res.day_of_month = days_reg[4:0] + 5'd1;
    end

endmodule

`default_nettype wire
